// File: hdl/audio_port_rate_and_transfer_time_core_assert.svh
// Assertion macros for the audio port rate and transfer time core.
// Used by the checker module; depends on nothing else.
`ifndef AUDIO_PORT_RATE_AND_TRANSFER_TIME_CORE_ASSERT_SVH
`define AUDIO_PORT_RATE_AND_TRANSFER_TIME_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define APRTT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aprtt assertion failed");

// Next-cycle implication, checked outside reset.
`define APRTT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aprtt assertion failed");

`endif

// File: hdl/aprtt_pkg.sv
// Shared types and constants for the audio port rate and transfer time core.
// Used by aprtt_front, aprtt_div, the top level and the testbench; depends on nothing.
package aprtt_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_SRC0 = 3'd0;
    localparam logic [2:0] CFG_SRC1 = 3'd1;
    localparam logic [2:0] CFG_SRC2 = 3'd2;
    localparam logic [2:0] CFG_SRC3 = 3'd3;
    localparam logic [2:0] CFG_CPU  = 3'd4;

    localparam logic [9:0]  CPU_MHZ_RESET      = 10'd160;
    localparam logic [31:0] FALLBACK_RATE      = 32'd48000;
    localparam logic [19:0] HZ_PER_MHZ         = 20'd1000000;
    localparam logic [11:0] MAX_TRANSFER_BYTES = 12'd4095;

    // Shared divider geometry: numerator and divisor widths.
    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 41;

    typedef struct packed {
        logic [3:0][31:0] src_hz;
        logic [9:0]       cpu_mhz;
    } t_cfg;

    // Per-transaction data that rides alongside the dividers.
    typedef struct packed {
        logic [31:0] rate;
        logic [5:0]  bits;
        logic [4:0]  chans;
        logic [41:0] lencpu;
        logic        zero;
    } t_side;

endpackage

// File: hdl/aprtt_front.sv
// Front end: fraction decode, channel count and the divisor products, three stages.
// Depends on aprtt_pkg.
module aprtt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  aprtt_pkg::t_cfg               i_cfg,
    input  logic [1:0]                    i_clock_select,
    input  logic [7:0]                    i_integer_divider,
    input  logic [27:0]                   i_fraction_word,
    input  logic [5:0]                    i_bit_clock_divider_field,
    input  logic [4:0]                    i_channel_width_field,
    input  logic [4:0]                    i_sample_width_field,
    input  logic [3:0]                    i_slot_count_field,
    input  logic [15:0]                   i_slot_enable_mask,
    input  logic                          i_mono_mode,
    input  logic [11:0]                   i_transfer_length,
    output logic                          o_valid,
    output logic [aprtt_pkg::DIV_NUM_W-1:0] o_num,
    output logic [aprtt_pkg::DIV_DEN_W-1:0] o_den,
    output aprtt_pkg::t_side              o_side
);
    import aprtt_pkg::*;

    // Stage 1 registers.
    logic        r_v1;
    logic [17:0] r_den1, r_num1;
    logic [7:0]  r_int1;
    logic [31:0] r_src1;
    logic [11:0] r_bckch1;
    logic [4:0]  r_slots1, r_chans1;
    logic [5:0]  r_bits1;
    logic [11:0] r_len1;
    logic [29:0] r_cpuhz1;

    logic [8:0]  n_z, n_y, n_x;
    logic [18:0] n_den19;
    logic [17:0] n_den, n_num;
    logic [4:0]  n_slots, n_cnt, n_chans;
    logic [16:0] n_mask17;
    logic [15:0] n_used;

    // Decode the fraction and count enabled slots.
    always_comb begin
        n_z = i_fraction_word[8:0];
        n_y = i_fraction_word[17:9];
        n_x = i_fraction_word[26:18];
        n_den19 = 19'({1'b0, n_x} + 10'd1) * 19'(n_z) + 19'(n_y);
        n_den = (n_z == 9'd0) ? 18'd1 : n_den19[17:0];
        if (n_z == 9'd0) begin
            n_num = 18'd0;
        end else if (i_fraction_word[27]) begin
            n_num = n_den - 18'(n_z);
        end else begin
            n_num = 18'(n_z);
        end
        n_slots = 5'(i_slot_count_field) + 5'd1;
        n_mask17 = (17'd1 << n_slots) - 17'd1;
        n_used = i_slot_enable_mask & n_mask17[15:0];
        n_cnt = 5'd0;
        for (int k = 0; k < 16; k++) begin
            n_cnt = n_cnt + 5'(n_used[k]);
        end
        if (i_mono_mode) begin
            n_chans = 5'd1;
        end else if (n_cnt != 5'd0) begin
            n_chans = n_cnt;
        end else begin
            n_chans = n_slots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den1   <= n_den;
            r_num1   <= n_num;
            r_int1   <= i_integer_divider;
            r_src1   <= i_cfg.src_hz[i_clock_select];
            r_bckch1 <= 12'(7'(i_bit_clock_divider_field) + 7'd1)
                        * 12'(6'(i_channel_width_field) + 6'd1);
            r_slots1 <= n_slots;
            r_chans1 <= n_chans;
            r_bits1  <= 6'(i_sample_width_field) + 6'd1;
            r_len1   <= (i_transfer_length > MAX_TRANSFER_BYTES) ? MAX_TRANSFER_BYTES
                                                                  : i_transfer_length;
            r_cpuhz1 <= 30'(i_cfg.cpu_mhz) * 30'(HZ_PER_MHZ);
        end
    end

    // Stage 2: divider word, scaled source, frame factor and length times clock.
    logic        r_v2;
    logic [25:0] r_clkdiv2;
    logic [49:0] r_srcden2;
    logic [15:0] r_fmt2;
    logic [41:0] r_lencpu2;
    logic        r_srczero2;
    logic [5:0]  r_bits2;
    logic [4:0]  r_chans2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clkdiv2  <= 26'(r_int1) * 26'(r_den1) + 26'(r_num1);
            r_srcden2  <= 50'(r_src1) * 50'(r_den1);
            r_fmt2     <= 16'(r_bckch1) * 16'(r_slots1);
            r_lencpu2  <= 42'(r_len1) * 42'(r_cpuhz1);
            r_srczero2 <= (r_src1 == 32'd0);
            r_bits2    <= r_bits1;
            r_chans2   <= r_chans1;
        end
    end

    // Stage 3: full divisor and the zero-rate flag.
    logic                 r_v3;
    logic [DIV_DEN_W-1:0] r_div3;
    logic [49:0]          r_srcden3;
    t_side                r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div3         <= DIV_DEN_W'(r_clkdiv2) * DIV_DEN_W'(r_fmt2);
            r_srcden3      <= r_srcden2;
            r_side3.rate   <= 32'd0;
            r_side3.bits   <= r_bits2;
            r_side3.chans  <= r_chans2;
            r_side3.lencpu <= r_lencpu2;
            r_side3.zero   <= r_srczero2 || (r_clkdiv2 == 26'd0);
        end
    end

    assign o_valid = r_v3;
    assign o_num   = DIV_NUM_W'(r_srcden3);
    assign o_den   = r_div3;
    assign o_side  = r_side3;

endmodule

// File: hdl/aprtt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on aprtt_pkg.
module aprtt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [aprtt_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [aprtt_pkg::DIV_DEN_W-1:0] i_den,
    input  aprtt_pkg::t_side                i_side,
    output logic                            o_valid,
    output logic [aprtt_pkg::DIV_NUM_W-1:0] o_quot,
    output logic                            o_rem_nz,
    output aprtt_pkg::t_side                o_side
);
    import aprtt_pkg::*;

    logic [DIV_NUM_W:1]   r_vld;
    logic [DIV_DEN_W-1:0] r_rem  [1:DIV_NUM_W];
    logic [DIV_NUM_W-1:0] r_num  [1:DIV_NUM_W];
    logic [DIV_NUM_W-1:0] r_quot [1:DIV_NUM_W];
    logic [DIV_DEN_W-1:0] r_den  [1:DIV_NUM_W];
    t_side                r_side [1:DIV_NUM_W];

    logic                 s_vld  [0:DIV_NUM_W-1];
    logic [DIV_DEN_W-1:0] s_rem  [0:DIV_NUM_W-1];
    logic [DIV_NUM_W-1:0] s_num  [0:DIV_NUM_W-1];
    logic [DIV_NUM_W-1:0] s_quot [0:DIV_NUM_W-1];
    logic [DIV_DEN_W-1:0] s_den  [0:DIV_NUM_W-1];
    t_side                s_side [0:DIV_NUM_W-1];

    // Stage inputs: the ports for the first stage, the previous register otherwise.
    always_comb begin
        s_vld[0]  = i_valid;
        s_rem[0]  = '0;
        s_num[0]  = i_num;
        s_quot[0] = '0;
        s_den[0]  = i_den;
        s_side[0] = i_side;
        for (int k = 1; k < DIV_NUM_W; k++) begin
            s_vld[k]  = r_vld[k];
            s_rem[k]  = r_rem[k];
            s_num[k]  = r_num[k];
            s_quot[k] = r_quot[k];
            s_den[k]  = r_den[k];
            s_side[k] = r_side[k];
        end
    end

    for (genvar g = 0; g < DIV_NUM_W; g++) begin : g_stage
        logic [DIV_DEN_W:0] n_trial;
        logic               n_qbit;

        // Shift in the next numerator bit and try to subtract the divisor.
        always_comb begin
            n_trial = {s_rem[g], s_num[g][DIV_NUM_W-1]};
            n_qbit  = (n_trial >= {1'b0, s_den[g]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_qbit ? DIV_DEN_W'(n_trial - {1'b0, s_den[g]})
                                      : DIV_DEN_W'(n_trial);
                r_num[g+1]  <= s_num[g] << 1;
                r_quot[g+1] <= {s_quot[g][DIV_NUM_W-2:0], n_qbit};
                r_den[g+1]  <= s_den[g];
                r_side[g+1] <= s_side[g];
            end
        end
    end

    assign o_valid  = r_vld[DIV_NUM_W];
    assign o_quot   = r_quot[DIV_NUM_W];
    assign o_rem_nz = (r_rem[DIV_NUM_W] != '0);
    assign o_side   = r_side[DIV_NUM_W];

endmodule

// File: hdl/audio_port_rate_and_transfer_time_core.sv
// Audio port rate and transfer time core, top level.
// Depends on aprtt_pkg, aprtt_front and aprtt_div.
//
// Usage: each input transaction carries one set of serial port divider and
// frame format fields plus a buffer length; each produces exactly one result
// transaction with the frame rate, sample width, channel count and the
// processor cycles needed to move the buffer.
// Channels: input i_valid / o_stall, output o_valid / i_stall; a transaction
// moves when valid is high and stall is low. Configuration is a separate
// valid/ready write port (always ready) holding four source clocks and the
// processor clock in MHz; write it only while the core is empty.
// The pipeline holds three front-end stages, a 50-stage rate divider, one
// stage forming bytes per second, a 50-stage cycle divider and the output
// register. Throughput is one transaction per cycle while the receiver does
// not stall; the depth of the two pipelined dividers sets the latency.
// Reset empties the pipeline, clears the source clocks and sets the
// processor clock to 160 MHz. While the receiver stalls a held result, the
// whole pipeline freezes and o_stall is raised; nothing is lost or repeated.
module audio_port_rate_and_transfer_time_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_clock_select,
    input  logic [7:0]  i_integer_divider,
    input  logic [27:0] i_fraction_word,
    input  logic [5:0]  i_bit_clock_divider_field,
    input  logic [4:0]  i_channel_width_field,
    input  logic [4:0]  i_sample_width_field,
    input  logic [3:0]  i_slot_count_field,
    input  logic [15:0] i_slot_enable_mask,
    input  logic        i_mono_mode,
    input  logic [11:0] i_transfer_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample_rate,
    output logic [5:0]  o_bits_per_sample,
    output logic [4:0]  o_channel_count,
    output logic [41:0] o_transfer_cycles
);
    import aprtt_pkg::*;

    t_cfg r_cfg;
    logic w_en;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_hz  <= '0;
            r_cfg.cpu_mhz <= CPU_MHZ_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SRC0: r_cfg.src_hz[0] <= i_cfg_data;
                CFG_SRC1: r_cfg.src_hz[1] <= i_cfg_data;
                CFG_SRC2: r_cfg.src_hz[2] <= i_cfg_data;
                CFG_SRC3: r_cfg.src_hz[3] <= i_cfg_data;
                CFG_CPU:  r_cfg.cpu_mhz   <= i_cfg_data[9:0];
                default:  ;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a result.
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    logic                 w_f_valid;
    logic [DIV_NUM_W-1:0] w_f_num;
    logic [DIV_DEN_W-1:0] w_f_den;
    t_side                w_f_side;

    aprtt_front u_front (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_en                      (w_en),
        .i_valid                   (i_valid),
        .i_cfg                     (r_cfg),
        .i_clock_select            (i_clock_select),
        .i_integer_divider         (i_integer_divider),
        .i_fraction_word           (i_fraction_word),
        .i_bit_clock_divider_field (i_bit_clock_divider_field),
        .i_channel_width_field     (i_channel_width_field),
        .i_sample_width_field      (i_sample_width_field),
        .i_slot_count_field        (i_slot_count_field),
        .i_slot_enable_mask        (i_slot_enable_mask),
        .i_mono_mode               (i_mono_mode),
        .i_transfer_length         (i_transfer_length),
        .o_valid                   (w_f_valid),
        .o_num                     (w_f_num),
        .o_den                     (w_f_den),
        .o_side                    (w_f_side)
    );

    logic                 w_d1_valid, w_d1_nz;
    logic [DIV_NUM_W-1:0] w_d1_quot;
    t_side                w_d1_side;

    aprtt_div u_rate_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_f_valid),
        .i_num    (w_f_num),
        .i_den    (w_f_den),
        .i_side   (w_f_side),
        .o_valid  (w_d1_valid),
        .o_quot   (w_d1_quot),
        .o_rem_nz (w_d1_nz),
        .o_side   (w_d1_side)
    );

    // Rate saturation, fallback rate and bytes per second.
    logic [31:0] n_rate, n_trate;
    logic [6:0]  n_bpc;
    logic [38:0] n_bytes;
    t_side       n_side;
    always_comb begin
        if (w_d1_side.zero) begin
            n_rate = 32'd0;
        end else if (w_d1_quot[DIV_NUM_W-1:32] != '0) begin
            n_rate = 32'hFFFF_FFFF;
        end else begin
            n_rate = w_d1_quot[31:0];
        end
        n_trate = (n_rate != 32'd0) ? n_rate : FALLBACK_RATE;
        n_bpc   = (w_d1_side.bits > 6'd16) ? (7'(w_d1_side.chans) << 2)
                                           : (7'(w_d1_side.chans) << 1);
        n_bytes = 39'(n_trate) * 39'(n_bpc);
        n_side      = w_d1_side;
        n_side.rate = n_rate;
    end

    logic                 r_m_valid;
    logic [DIV_DEN_W-1:0] r_m_den;
    t_side                r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_den  <= DIV_DEN_W'(n_bytes[37:0]);
            r_m_side <= n_side;
        end
    end

    logic                 w_d2_valid, w_d2_nz;
    logic [DIV_NUM_W-1:0] w_d2_quot;
    t_side                w_d2_side;

    aprtt_div u_cyc_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_m_valid),
        .i_num    (DIV_NUM_W'(r_m_side.lencpu)),
        .i_den    (r_m_den),
        .i_side   (r_m_side),
        .o_valid  (w_d2_valid),
        .o_quot   (w_d2_quot),
        .o_rem_nz (w_d2_nz),
        .o_side   (w_d2_side)
    );

    // Round the cycle count up, with a floor of one.
    logic [42:0] n_cyc;
    always_comb begin
        n_cyc = w_d2_quot[42:0] + 43'(w_d2_nz);
        if (n_cyc == 43'd0) begin
            n_cyc = 43'd1;
        end
    end

    logic r_o_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_sample_rate     <= w_d2_side.rate;
            o_bits_per_sample <= w_d2_side.bits;
            o_channel_count   <= w_d2_side.chans;
            o_transfer_cycles <= n_cyc[41:0];
        end
    end

    assign o_valid = r_o_valid;

endmodule

// File: hdl/aprtt_checker.sv
// Port-level checker for the audio port rate and transfer time core, and its bind.
// Depends on audio_port_rate_and_transfer_time_core_assert.svh.
`include "audio_port_rate_and_transfer_time_core_assert.svh"

module aprtt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_bits_per_sample,
    input logic [4:0]  o_channel_count,
    input logic [41:0] o_transfer_cycles
);

    // A held result keeps its valid while the receiver stalls.
    `APRTT_ASSERT_NXT(a_hold_valid, o_valid && i_stall, o_valid)

    // The input side only stalls while a result is held back.
    `APRTT_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)

    // Result fields stay in their decoded ranges.
    `APRTT_ASSERT_IMP(a_fmt_range, o_valid, (o_bits_per_sample != 6'd0) && (o_bits_per_sample <= 6'd32) && (o_channel_count != 5'd0) && (o_channel_count <= 5'd16))

    // Transfer time is never zero.
    `APRTT_ASSERT_IMP(a_cycles_min, o_valid, o_transfer_cycles != 42'd0)

endmodule

bind audio_port_rate_and_transfer_time_core aprtt_checker u_aprtt_checker (.*);

// File: tb/audio_port_rate_and_transfer_time_core_tb.sv
// Self-checking testbench for the audio port rate and transfer time core.
// Drives divider and frame format transactions, predicts each result and compares them.
// Depends on aprtt_pkg and audio_port_rate_and_transfer_time_core.
module audio_port_rate_and_transfer_time_core_tb;
    import aprtt_pkg::*;

    typedef struct packed {
        logic [1:0]  clock_select;
        logic [7:0]  integer_divider;
        logic [27:0] fraction_word;
        logic [5:0]  bck_field;
        logic [4:0]  chan_width_field;
        logic [4:0]  sample_width_field;
        logic [3:0]  slot_count_field;
        logic [15:0] slot_enable_mask;
        logic        mono_mode;
        logic [11:0] transfer_length;
    } t_port_query;

    typedef struct packed {
        logic [31:0] sample_rate;
        logic [5:0]  bits_per_sample;
        logic [4:0]  channel_count;
        logic [41:0] transfer_cycles;
    } t_port_timing;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_SRC0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_port_query query_drv = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_sample_rate;
    logic [5:0]  o_bits_per_sample;
    logic [4:0]  o_channel_count;
    logic [41:0] o_transfer_cycles;

    // Configuration shadow used by the predictor.
    logic [31:0] src_hz_shadow [4];
    logic [9:0]  cpu_mhz_shadow;

    t_port_query  query_q [$];
    t_port_timing timing_q [$];
    int sender_idle_pct = 38;
    int receiver_stall_pct = 68;
    int mismatch_count = 0;
    int accepted_queries = 0;
    int checked_results = 0;
    int quiet_cycles = 0;

    audio_port_rate_and_transfer_time_core uut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_valid               (i_cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_cfg_index               (i_cfg_index),
        .i_cfg_data                (i_cfg_data),
        .i_valid                   (i_valid),
        .o_stall                   (o_stall),
        .i_clock_select            (query_drv.clock_select),
        .i_integer_divider         (query_drv.integer_divider),
        .i_fraction_word           (query_drv.fraction_word),
        .i_bit_clock_divider_field (query_drv.bck_field),
        .i_channel_width_field     (query_drv.chan_width_field),
        .i_sample_width_field      (query_drv.sample_width_field),
        .i_slot_count_field        (query_drv.slot_count_field),
        .i_slot_enable_mask        (query_drv.slot_enable_mask),
        .i_mono_mode               (query_drv.mono_mode),
        .i_transfer_length         (query_drv.transfer_length),
        .o_valid                   (o_valid),
        .i_stall                   (i_stall),
        .o_sample_rate             (o_sample_rate),
        .o_bits_per_sample         (o_bits_per_sample),
        .o_channel_count           (o_channel_count),
        .o_transfer_cycles         (o_transfer_cycles)
    );

    // Clock with a 20 unit period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Computes frame rate, format and transfer time for one query.
    function automatic t_port_timing port_timing(t_port_query q);
        longint unsigned z, y, x, den, num, clkdiv, divisor, src, rate_wide;
        longint unsigned bck, chbits, bits, slots, chans, trate, bps;
        longint unsigned bytes_per_sec, cpu_hz, cycles;
        logic [15:0] used;
        t_port_timing r;
        z = q.fraction_word[8:0];
        y = q.fraction_word[17:9];
        x = q.fraction_word[26:18];
        den = 1;
        num = 0;
        if (z != 0) begin
            den = (x + 1) * z + y;
            num = q.fraction_word[27] ? den - z : z;
        end
        bck = q.bck_field + 1;
        chbits = q.chan_width_field + 1;
        bits = q.sample_width_field + 1;
        slots = q.slot_count_field + 1;
        clkdiv = q.integer_divider * den + num;
        divisor = clkdiv * bck * chbits * slots;
        src = src_hz_shadow[q.clock_select];
        rate_wide = 0;
        if (src != 0 && divisor != 0) begin
            rate_wide = src * den / divisor;
            if (rate_wide > 64'hFFFF_FFFF) rate_wide = 64'hFFFF_FFFF;
        end
        // Only slots in use count; none enabled means all slots.
        if (q.mono_mode) begin
            chans = 1;
        end else begin
            used = q.slot_enable_mask & ((slots == 16) ? 16'hFFFF : 16'((1 << slots) - 1));
            chans = $countones(used);
            if (chans == 0) chans = slots;
        end
        trate = (rate_wide != 0) ? rate_wide : 48000;
        bps = (bits + 15) / 16 * 2;
        bytes_per_sec = trate * bps * chans;
        cpu_hz = cpu_mhz_shadow * 64'd1000000;
        cycles = 1;
        if (cpu_hz != 0) begin
            cycles = (q.transfer_length * cpu_hz + bytes_per_sec - 1) / bytes_per_sec;
            if (cycles == 0) cycles = 1;
        end
        r.sample_rate = rate_wide[31:0];
        r.bits_per_sample = bits[5:0];
        r.channel_count = chans[4:0];
        r.transfer_cycles = cycles[41:0];
        return r;
    endfunction

    // Driver: presents queued queries and predicts each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                timing_q.push_back(port_timing(query_drv));
                accepted_queries++;
            end
            if (!i_valid || !o_stall) begin
                if (query_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    query_drv <= query_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and comparison with the oldest prediction.
    always @(posedge i_clk) begin
        t_port_timing want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
            if (o_valid && !i_stall) begin
                checked_results++;
                if (timing_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transaction: rate %0d", o_sample_rate);
                end else begin
                    want = timing_q.pop_front();
                    if (want.sample_rate !== o_sample_rate
                        || want.bits_per_sample !== o_bits_per_sample
                        || want.channel_count !== o_channel_count
                        || want.transfer_cycles !== o_transfer_cycles) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: exp rate %0d bits %0d ch %0d cyc %0d, got %0d %0d %0d %0d",
                                     want.sample_rate, want.bits_per_sample,
                                     want.channel_count, want.transfer_cycles,
                                     o_sample_rate, o_bits_per_sample,
                                     o_channel_count, o_transfer_cycles);
                    end
                end
            end
        end
    end

    // Configuration shadow follows each accepted register write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) src_hz_shadow[k] <= '0;
            cpu_mhz_shadow <= CPU_MHZ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CPU) cpu_mhz_shadow <= i_cfg_data[9:0];
            else src_hz_shadow[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("audio_port_rate_and_transfer_time_core_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                             logic [31:0] s3, logic [9:0] cpu);
        write_reg(CFG_SRC0, s0);
        write_reg(CFG_SRC1, s1);
        write_reg(CFG_SRC2, s2);
        write_reg(CFG_SRC3, s3);
        write_reg(CFG_CPU, {22'd0, cpu});
    endtask

    // Waits until every prediction has been checked, then lets the pipeline drain.
    task automatic drain();
        while (query_q.size() != 0 || i_valid || timing_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic t_port_query random_query();
        t_port_query q;
        q = t_port_query'({$urandom, $urandom, $urandom});
        case ($urandom_range(7))
            0: q.fraction_word[8:0] = '0;
            1: q.integer_divider = '0;
            2: q.fraction_word = {1'b1, 18'd0, q.fraction_word[8:0]};
            3: q.slot_enable_mask = '0;
            default: ;
        endcase
        return q;
    endfunction

    task automatic push_directed();
        t_port_query q;
        q = '0;
        query_q.push_back(q);                     // all zero: zero divisor
        q = '1;
        query_q.push_back(q);                     // all ones
        q = '0; q.integer_divider = 8'd4; q.fraction_word = 28'd0;
        q.bck_field = 6'd7; q.chan_width_field = 5'd31; q.slot_count_field = 4'd1;
        q.sample_width_field = 5'd15; q.transfer_length = 12'd4095;
        query_q.push_back(q);                     // plain integer divider
        q.fraction_word = {1'b0, 9'd0, 9'd3, 9'd5};
        query_q.push_back(q);                     // fraction z/y path
        q.fraction_word = {1'b1, 9'd2, 9'd3, 9'd5};
        query_q.push_back(q);                     // yn1 set
        q.integer_divider = 8'd0; q.fraction_word = {1'b1, 9'd0, 9'd0, 9'd7};
        query_q.push_back(q);                     // yn1 giving zero numerator
        q.integer_divider = 8'd0; q.fraction_word = {1'b0, 9'd0, 9'd0, 9'd1};
        q.bck_field = 6'd0; q.chan_width_field = 5'd0; q.slot_count_field = 4'd0;
        query_q.push_back(q);                     // smallest divisor, rate equals the source clock
        q.fraction_word = {1'b0, 9'h1FF, 9'h1FF, 9'h1FF};
        q.integer_divider = 8'd255; q.bck_field = 6'd63; q.chan_width_field = 5'd31;
        q.slot_count_field = 4'd15;
        query_q.push_back(q);                     // large divisor
        for (int s = 0; s < 4; s++) begin
            q = '0; q.clock_select = s[1:0]; q.integer_divider = 8'd2;
            q.slot_count_field = 4'd3; q.slot_enable_mask = 16'hFFF0;
            q.sample_width_field = 5'd16; q.transfer_length = 12'd1;
            query_q.push_back(q);                 // enables above slot count ignored
        end
        q.slot_enable_mask = 16'h0005; q.mono_mode = 1'b1;
        query_q.push_back(q);                     // mono
        q.mono_mode = 1'b0; q.slot_count_field = 4'd15; q.slot_enable_mask = 16'hFFFF;
        query_q.push_back(q);                     // sixteen slots
        q.slot_enable_mask = 16'h0000; q.transfer_length = 12'd0;
        query_q.push_back(q);                     // no enabled slot, zero length
    endtask

    initial begin
        logic [31:0] r0, r1, r2;
        logic [9:0]  cpu;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset configuration: every source clock is zero.
        push_directed();
        drain();
        write_all(32'd24576000, 32'd22579200, 32'd12288000, 32'd0, 10'd240);
        push_directed();
        drain();
        for (int p = 1; p <= 6; p++) begin
            if (p == 3) begin
                sender_idle_pct = 68; receiver_stall_pct = 38;
            end else if (p == 5) begin
                sender_idle_pct = 0; receiver_stall_pct = 0;
            end
            r0 = $urandom; r1 = $urandom; r2 = $urandom;
            cpu = 10'($urandom_range(1000));
            case (p)
                1: write_all(32'd49152000, 32'd11289600, 32'd1, 32'd6144000, 10'd1000);
                2: write_all('1, '1, '1, '1, 10'd0);
                3: write_all(r0, r1, r2, 32'd0, cpu);
                4: write_all(32'd1, 32'd2, r0 >> 8, r1, 10'd1);
                5: write_all(r2, r0, r1 >> 4, 32'hFFFF_FFFF, cpu);
                default: write_all(32'd24576000, r0, r1, r2, 10'd160);
            endcase
            push_directed();
            for (int n = 0; n < 200; n++) query_q.push_back(random_query());
            drain();
        end
        if (timing_q.size() != 0) mismatch_count++;
        $display("Checked %0d of %0d queries over eight configurations and three idle profiles.",
                 checked_results, accepted_queries);
        if (mismatch_count == 0)
            $display("audio_port_rate_and_transfer_time_core_tb OK");
        else
            $display("audio_port_rate_and_transfer_time_core_tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/aprtt_pkg.sv
hdl/aprtt_front.sv
hdl/aprtt_div.sv
hdl/audio_port_rate_and_transfer_time_core.sv
hdl/aprtt_checker.sv
tb/audio_port_rate_and_transfer_time_core_tb.sv
